// File: sv/prqs_pkg.sv
// Shared types and constants for the priority ready-queue scheduler.
package prqs_pkg;

  localparam int ThreadCountDef    = 32;
  localparam int PriorityLevelsDef = 8;
  localparam int IdW               = 5;
  localparam int LvW               = 3;

  typedef enum logic [2:0] {
    OP_ADMIT   = 3'd0,
    OP_YIELD   = 3'd1,
    OP_WAKE    = 3'd2,
    OP_SETPRIO = 3'd3,
    OP_BLOCK   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_WAITING  = 3'd3,
    ST_FINISHED = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]     operation;
    logic [IdW-1:0] thread_id;
    logic [LvW-1:0] new_priority;
  } in_beat_t;

  typedef struct packed {
    logic [IdW-1:0] running_thread;
    logic           cpu_idle;
    logic           switched;
    logic           accepted;
  } out_beat_t;

  // Datapath commands, one per cycle.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,      // latch the input beat, look up thread state
    CMD_ADMIT,     // set level, ready, push
    CMD_WAKE,      // ready, push at own level
    CMD_MARK_WAIT, // running thread becomes waiting
    CMD_REQUEUE,   // running thread becomes ready, pushed
    CMD_SETLV,     // write new level of addressed thread
    CMD_RM_HEAD,   // pop addressed thread off head of old level
    CMD_WALK,      // one step of the removal walk
    CMD_PUSH_ID,   // push addressed thread at new level
    CMD_SWITCH,    // dispatch head of top level or go idle
    CMD_REJECT     // flag set priority as not accepted
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       id_ok;
    status_t    id_status;
    logic       cur_valid;
    logic       any_ready;
    logic       cur_outranks;  // running level above every ready level
    logic       new_beats_cur; // new level above running level
    logic       rm_at_head;    // addressed thread heads its old queue
    logic       rm_occ;        // old queue occupied
    logic       walk_done;     // walk found the thread or ran out
  } status_bus_t;

endpackage

// File: sv/prqs_datapath.sv
// Scheduler datapath: thread tables, linked ready queues and running thread.
module prqs_datapath #(
  parameter int ThreadCount    = prqs_pkg::ThreadCountDef,
  parameter int PriorityLevels = prqs_pkg::PriorityLevelsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  prqs_pkg::cmd_t        cmd,
  input  prqs_pkg::in_beat_t    in_beat,
  output prqs_pkg::status_bus_t sts,
  output prqs_pkg::out_beat_t   res
);
  localparam int TW = (ThreadCount > 1) ? $clog2(ThreadCount) : 1;
  localparam int LW = (PriorityLevels > 1) ? $clog2(PriorityLevels) : 1;
  localparam int CW = $clog2(ThreadCount + 1);

  prqs_pkg::status_t status_r [ThreadCount];
  logic [LW-1:0]     level_r  [ThreadCount];
  logic [TW-1:0]     link_r   [ThreadCount];
  logic [TW-1:0]     head_r   [PriorityLevels];
  logic [TW-1:0]     tail_r   [PriorityLevels];
  logic [PriorityLevels-1:0] occ_r;
  logic [TW-1:0]     cur_r;
  logic              cur_valid_r;

  logic [2:0]        op_r;
  logic [TW-1:0]     id_r;
  logic              id_ok_r;
  logic [LW-1:0]     nlv_r;
  logic [LW-1:0]     oldlv_r;
  logic [TW-1:0]     prev_r;
  logic [CW-1:0]     n_r;
  logic              sw_r;
  logic              acc_r;

  logic [LW-1:0] top_lv;
  logic          any_rdy;
  logic [LW-1:0] sat_lv;
  logic [TW-1:0] nx;

  always_comb begin
    top_lv  = '0;
    any_rdy = 1'b0;
    for (int i = 0; i < PriorityLevels; i++) begin
      if (occ_r[i]) begin
        top_lv  = LW'(i);
        any_rdy = 1'b1;
      end
    end
  end

  always_comb begin
    if (32'(in_beat.new_priority) > 32'(PriorityLevels - 1)) begin
      sat_lv = LW'(PriorityLevels - 1);
    end else begin
      sat_lv = LW'(in_beat.new_priority);
    end
  end

  assign nx = link_r[prev_r];

  always_comb begin
    sts.op            = op_r;
    sts.id_ok         = id_ok_r;
    sts.id_status     = status_r[id_r];
    sts.cur_valid     = cur_valid_r;
    sts.any_ready     = any_rdy;
    sts.cur_outranks  = !any_rdy || (level_r[cur_r] > top_lv);
    sts.new_beats_cur = nlv_r > level_r[cur_r];
    sts.rm_at_head    = head_r[oldlv_r] == id_r;
    sts.rm_occ        = occ_r[oldlv_r];
    sts.walk_done     = (prev_r == tail_r[oldlv_r]) || (n_r >= CW'(ThreadCount))
                        || (nx == id_r);
    res.running_thread = cur_valid_r ? prqs_pkg::IdW'(cur_r) : '0;
    res.cpu_idle       = !cur_valid_r;
    res.switched       = sw_r;
    res.accepted       = acc_r;
  end

  logic [TW-1:0] pid;
  logic [LW-1:0] plv;
  logic          pdo;

  always_comb begin
    pid = id_r;
    plv = nlv_r;
    pdo = 1'b0;
    unique case (cmd)
      prqs_pkg::CMD_ADMIT, prqs_pkg::CMD_PUSH_ID: pdo = 1'b1;
      prqs_pkg::CMD_WAKE: begin
        pdo = 1'b1;
        plv = level_r[id_r];
      end
      prqs_pkg::CMD_REQUEUE: begin
        pdo = 1'b1;
        pid = cur_r;
        plv = level_r[cur_r];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ThreadCount; i++) begin
        status_r[i] <= prqs_pkg::ST_UNUSED;
        level_r[i]  <= '0;
        link_r[i]   <= '0;
      end
      for (int i = 0; i < PriorityLevels; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
      occ_r       <= '0;
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
      sw_r        <= 1'b0;
      acc_r       <= 1'b1;
      op_r <= '0; id_r <= '0; id_ok_r <= 1'b0; nlv_r <= '0;
      oldlv_r <= '0; prev_r <= '0; n_r <= '0;
    end else begin
      if (pdo) begin
        if (!occ_r[plv]) begin
          head_r[plv] <= pid;
          occ_r[plv]  <= 1'b1;
        end else begin
          link_r[tail_r[plv]] <= pid;
        end
        tail_r[plv] <= pid;
      end
      unique case (cmd)
        prqs_pkg::CMD_LOAD: begin
          op_r    <= in_beat.operation;
          id_r    <= TW'(in_beat.thread_id);
          id_ok_r <= 32'(in_beat.thread_id) < ThreadCount;
          nlv_r   <= sat_lv;
          oldlv_r <= level_r[TW'(in_beat.thread_id)];
          sw_r    <= 1'b0;
          acc_r   <= 1'b1;
        end
        prqs_pkg::CMD_ADMIT: begin
          level_r[id_r]  <= nlv_r;
          status_r[id_r] <= prqs_pkg::ST_READY;
        end
        prqs_pkg::CMD_WAKE: status_r[id_r] <= prqs_pkg::ST_READY;
        prqs_pkg::CMD_MARK_WAIT: status_r[cur_r] <= prqs_pkg::ST_WAITING;
        prqs_pkg::CMD_REQUEUE: status_r[cur_r] <= prqs_pkg::ST_READY;
        prqs_pkg::CMD_SETLV: begin
          level_r[id_r] <= nlv_r;
          prev_r        <= head_r[oldlv_r];
          n_r           <= '0;
        end
        prqs_pkg::CMD_RM_HEAD: begin
          if (id_r == tail_r[oldlv_r]) occ_r[oldlv_r] <= 1'b0;
          else head_r[oldlv_r] <= link_r[id_r];
        end
        prqs_pkg::CMD_WALK: begin
          if (prev_r != tail_r[oldlv_r] && n_r < CW'(ThreadCount)) begin
            if (nx == id_r) begin
              link_r[prev_r] <= link_r[id_r];
              if (tail_r[oldlv_r] == id_r) tail_r[oldlv_r] <= prev_r;
            end else begin
              prev_r <= nx;
              n_r    <= n_r + 1'b1;
            end
          end
        end
        prqs_pkg::CMD_SWITCH: begin
          if (any_rdy) begin
            if (head_r[top_lv] == tail_r[top_lv]) occ_r[top_lv] <= 1'b0;
            else head_r[top_lv] <= link_r[head_r[top_lv]];
            status_r[head_r[top_lv]] <= prqs_pkg::ST_RUNNING;
            cur_r       <= head_r[top_lv];
            cur_valid_r <= 1'b1;
            sw_r        <= 1'b1;
          end else if (cur_valid_r && status_r[cur_r] != prqs_pkg::ST_RUNNING) begin
            cur_valid_r <= 1'b0;
          end
        end
        prqs_pkg::CMD_REJECT: acc_r <= 1'b0;
        default: ;
      endcase
    end
  end
endmodule

// File: sv/prqs_ctrl.sv
// Scheduler controller: sequences one operation and the handshakes.
module prqs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  prqs_pkg::status_bus_t sts,
  output prqs_pkg::cmd_t        cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_YIELD, S_SWITCH, S_WALK, S_PUSH, S_SP_YIELD, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;

  assign in_ready  = state_r == S_IDLE && !valid_r;
  assign out_valid = valid_r;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r && !out_ready;
    cmd       = prqs_pkg::CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd       = prqs_pkg::CMD_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        unique case (sts.op)
          prqs_pkg::OP_ADMIT:
            if (sts.id_ok && (sts.id_status == prqs_pkg::ST_UNUSED ||
                              sts.id_status == prqs_pkg::ST_FINISHED))
              cmd = prqs_pkg::CMD_ADMIT;
          prqs_pkg::OP_YIELD: state_nxt = S_YIELD;
          prqs_pkg::OP_WAKE:
            if (sts.id_ok && sts.id_status == prqs_pkg::ST_WAITING)
              cmd = prqs_pkg::CMD_WAKE;
          prqs_pkg::OP_SETPRIO: begin
            if (!sts.id_ok || sts.id_status == prqs_pkg::ST_UNUSED ||
                sts.id_status == prqs_pkg::ST_FINISHED ||
                sts.id_status > prqs_pkg::ST_FINISHED) begin
              cmd = prqs_pkg::CMD_REJECT;
            end else begin
              cmd = prqs_pkg::CMD_SETLV;
              state_nxt = (sts.id_status == prqs_pkg::ST_READY) ? S_WALK : S_SP_YIELD;
            end
          end
          prqs_pkg::OP_BLOCK: begin
            if (sts.cur_valid) cmd = prqs_pkg::CMD_MARK_WAIT;
            state_nxt = S_SWITCH;
          end
          default: ;
        endcase
      end
      S_YIELD: begin
        if (sts.cur_valid && sts.cur_outranks) begin
          state_nxt = S_DONE;
        end else begin
          if (sts.cur_valid) cmd = prqs_pkg::CMD_REQUEUE;
          state_nxt = S_SWITCH;
        end
      end
      S_SWITCH: begin
        cmd       = prqs_pkg::CMD_SWITCH;
        state_nxt = S_DONE;
      end
      S_WALK: begin
        if (!sts.rm_occ) begin
          state_nxt = S_PUSH;
        end else if (sts.rm_at_head) begin
          cmd       = prqs_pkg::CMD_RM_HEAD;
          state_nxt = S_PUSH;
        end else begin
          cmd = prqs_pkg::CMD_WALK;
          if (sts.walk_done) state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd       = prqs_pkg::CMD_PUSH_ID;
        state_nxt = S_SP_YIELD;
      end
      S_SP_YIELD: begin
        state_nxt = (sts.cur_valid && sts.new_beats_cur) ? S_YIELD : S_DONE;
      end
      S_DONE: begin
        if (!valid_r) begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end
endmodule

// File: sv/priority_ready_queue_scheduler_unit.sv
// Top level of the strict-priority multilevel ready-queue thread scheduler.
// channel | ports                          | payload
// input   | in_valid, in_ready, in_data    | operation, thread_id, new_priority
// result  | out_valid, out_ready, out_data | running_thread, cpu_idle, switched, accepted
// Admit, wake, rejected set priority and unknown codes go from load and decode to done;
// block adds a switch; yield adds a check, and a requeue and switch when it gives way. Set
// priority walks the old queue and pushes anew when the thread is ready, then may yield.
// One operation at a time, set by the sequencing FSM and single table ports.
// Synchronous active-low reset clears all tables.
// The result waits in the output register; in_ready returns the cycle after it leaves.
module priority_ready_queue_scheduler_unit #(
  parameter int ThreadCount    = prqs_pkg::ThreadCountDef,
  parameter int PriorityLevels = prqs_pkg::PriorityLevelsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prqs_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output prqs_pkg::out_beat_t out_data
);
  prqs_pkg::cmd_t        cmd;
  prqs_pkg::status_bus_t sts;

  prqs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  prqs_datapath #(.ThreadCount(ThreadCount), .PriorityLevels(PriorityLevels)) u_dp (
    .clk, .rst_n, .cmd, .in_beat(in_data), .sts, .res(out_data)
  );
endmodule
